// ===== hdl/qn_pkg.sv =====
`timescale 1ns / 1ps
package qn_pkg;

   localparam int C_W        = 16;   // component width
   localparam int SQR_W      = 32;   // one square
   localparam int SUM_W      = 33;   // sum of four squares
   localparam int RT_W       = 35;   // root/remainder width in the sqrt chain
   localparam int SQ_STEPS   = 18;   // sqrt cells, one per radicand bit pair
   localparam int M_W        = 17;   // rounded magnitude
   localparam int NUM_W      = 30;   // |c| * 2^14 + m/2
   localparam int Q_W        = 15;   // quotient bits
   localparam int DIV_STEPS  = 15;   // divider cells
   localparam int FRAC_BITS  = 14;
   localparam logic [Q_W-1:0] FRAC_ONE = Q_W'(16384);
   localparam logic [M_W-1:0] LEN_MAX  = M_W'(65535);

   typedef struct packed {
      logic [RT_W-1:0]         rem;
      logic [RT_W-1:0]         root;
      logic [3:0]              neg;
      logic [3:0][C_W-1:0]     mag;
      logic                    zero;
   } sq_word_type;

   typedef struct packed {
      logic [3:0][NUM_W-1:0]   rem;
      logic [3:0][Q_W-1:0]     quo;
      logic [M_W-1:0]          m;
      logic [3:0]              neg;
      logic                    zero;
   } div_word_type;

endpackage

// ===== hdl/qn_sqrt_cell.sv =====
`timescale 1ns / 1ps
module qn_sqrt_cell import qn_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        valid_in,
   input  sq_word_type word_in,
   output logic        valid_ff,
   output sq_word_type word_ff
);
   localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * STEP);

   logic [RT_W-1:0] trial;
   sq_word_type     word_in_nx;

   always_comb begin
      trial      = word_in.root + BIT;
      word_in_nx = word_in;
      if (word_in.rem >= trial) begin
         word_in_nx.rem  = word_in.rem - trial;
         word_in_nx.root = (word_in.root >> 1) + BIT;
      end else begin
         word_in_nx.root = word_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         word_ff <= word_in_nx;
      end
   end
endmodule

// ===== hdl/qn_div_cell.sv =====
`timescale 1ns / 1ps
module qn_div_cell import qn_pkg::*; #(
   parameter int BITP = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  logic         valid_in,
   input  div_word_type word_in,
   output logic         valid_ff,
   output div_word_type word_ff
);
   logic [NUM_W:0] shifted;
   div_word_type   word_in_nx;

   always_comb begin
      shifted    = (NUM_W + 1)'(word_in.m) << BITP;
      word_in_nx = word_in;
      for (int l = 0; l < 4; l++) begin
         if ({1'b0, word_in.rem[l]} >= shifted) begin
            word_in_nx.rem[l]       = word_in.rem[l] - shifted[NUM_W-1:0];
            word_in_nx.quo[l][BITP] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         word_ff <= word_in_nx;
      end
   end
endmodule

// ===== hdl/quaternion_normalize_top.sv =====
`timescale 1ns / 1ps
// channel | direction | word contents (low bit first)
// req     | in        | tdata: q_w, q_x, q_y, q_z (16 bits each, signed)
// rsp     | out       | tdata: length, unit_w, unit_x, unit_y, unit_z; tuser: zero_length
//
// One word enters per cycle unless the chain stalls. Stages: squares, sum, 18 square
// root cells, rounding, 15 divider cells (four lanes each), output register.
// The whole chain moves together: it stalls only while the output register
// holds a word that rsp_tready has not taken. Reset clears the valid bits.
module quaternion_normalize_top import qn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // q_w, q_x, q_y, q_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // length, unit_w, unit_x, unit_y, unit_z
   output logic [0:0]  rsp_tuser    // zero_length
);
   logic enable;
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   // squares
   logic                 sqr_valid_ff;
   logic [3:0][SQR_W-1:0] sqr_ff;
   logic [3:0][C_W-1:0]  mag_ff;
   logic [3:0]           neg_ff;
   logic [3:0][C_W-1:0]  mag_in;

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         mag_in[l] = req_tdata[l*C_W + C_W - 1] ? (~req_tdata[l*C_W +: C_W] + 1'b1)
                                                : req_tdata[l*C_W +: C_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqr_valid_ff <= 1'b0;
      end else if (enable) begin
         sqr_valid_ff <= req_tvalid;
      end
      if (enable) begin
         for (int l = 0; l < 4; l++) begin
            mag_ff[l] <= mag_in[l];
            neg_ff[l] <= req_tdata[l*C_W + C_W - 1];
            sqr_ff[l] <= mag_in[l] * mag_in[l];
         end
      end
   end

   // sum of squares, seeds the sqrt chain
   sq_word_type sq_word [SQ_STEPS+1];
   logic        sq_valid [SQ_STEPS+1];
   logic [SUM_W-1:0] sum;

   assign sum = SUM_W'(sqr_ff[0]) + SUM_W'(sqr_ff[1]) + SUM_W'(sqr_ff[2])
              + SUM_W'(sqr_ff[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid[0] <= 1'b0;
      end else if (enable) begin
         sq_valid[0] <= sqr_valid_ff;
      end
      if (enable) begin
         sq_word[0].rem  <= RT_W'(sum);
         sq_word[0].root <= '0;
         sq_word[0].neg  <= neg_ff;
         sq_word[0].mag  <= mag_ff;
         sq_word[0].zero <= (sum == '0);
      end
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      qn_sqrt_cell #(.STEP(SQ_STEPS - 1 - k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .valid_in (sq_valid[k]),
         .word_in  (sq_word[k]),
         .valid_ff (sq_valid[k+1]),
         .word_ff  (sq_word[k+1])
      );
   end

   // round to nearest and build numerators
   div_word_type div_word [DIV_STEPS+1];
   logic         div_valid [DIV_STEPS+1];
   logic [M_W-1:0] m_rnd;
   sq_word_type    sq_last;

   assign sq_last = sq_word[SQ_STEPS];
   assign m_rnd   = sq_last.root[M_W-1:0] + M_W'(sq_last.rem > sq_last.root);

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid[0] <= 1'b0;
      end else if (enable) begin
         div_valid[0] <= sq_valid[SQ_STEPS];
      end
      if (enable) begin
         div_word[0].m    <= m_rnd;
         div_word[0].neg  <= sq_last.neg;
         div_word[0].zero <= sq_last.zero;
         div_word[0].quo  <= '0;
         for (int l = 0; l < 4; l++) begin
            div_word[0].rem[l] <= ({NUM_W'(sq_last.mag[l]) << FRAC_BITS})
                                + NUM_W'(m_rnd >> 1);
         end
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      qn_div_cell #(.BITP(DIV_STEPS - 1 - j)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .valid_in (div_valid[j]),
         .word_in  (div_word[j]),
         .valid_ff (div_valid[j+1]),
         .word_ff  (div_word[j+1])
      );
   end

   // clamp, sign, saturate; output register
   div_word_type         dl;
   logic [3:0][C_W-1:0]  unit_in;
   logic [C_W-1:0]       length_in;
   logic [79:0]          data_ff;
   logic                 zero_ff;
   logic                 out_valid_ff;
   logic [Q_W-1:0]       qc;

   assign dl = div_word[DIV_STEPS];

   always_comb begin
      length_in = (dl.m > LEN_MAX) ? LEN_MAX[C_W-1:0] : dl.m[C_W-1:0];
      for (int l = 0; l < 4; l++) begin
         qc         = (dl.quo[l] > FRAC_ONE) ? FRAC_ONE : dl.quo[l];
         unit_in[l] = dl.neg[l] ? (~C_W'(qc) + 1'b1) : C_W'(qc);
         if (dl.zero) begin
            unit_in[l] = '0;
         end
      end
      if (dl.zero) begin
         length_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= div_valid[DIV_STEPS];
      end
      if (enable) begin
         data_ff <= {unit_in[3], unit_in[2], unit_in[1], unit_in[0], length_in};
         zero_ff <= dl.zero;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = zero_ff;
endmodule

// ===== tb/quaternion_normalize_top_tb.sv =====
`timescale 1ns / 1ps
// Normalizer bench: directed corner words, then random bursts.
// Expected results are computed in the bench and checked in arrival order.
module quaternion_normalize_top_tb;
   import qn_pkg::*;

   localparam int LATENCY     = 37;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [15:0] len;
      logic [15:0] uw;
      logic [15:0] ux;
      logic [15:0] uy;
      logic [15:0] uz;
      logic        zero;
   } norm_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // q_w, q_x, q_y, q_z
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;   // length, unit_w, unit_x, unit_y, unit_z
   logic [0:0]  rsp_tuser;   // zero_length

   norm_result_type expected_norms[$];
   int           fail_count;
   int           cycle_count;
   int           stall_mode;   // receiver pattern selector

   quaternion_normalize_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // floor(sqrt(s)), bitwise restoring
   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 34;
      while (bitv != 0) begin
         if (s >= root + bitv) begin
            s    = s - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // rounded |c|*2^14/m, ties away from zero, sign restored
   function automatic logic [15:0] unit_part(logic signed [15:0] c, longint unsigned m);
      longint unsigned mag;
      longint unsigned q;
      mag = (c < 0) ? longint'(-int'(c)) : longint'(c);
      q   = (mag * 16384 + (m >> 1)) / m;
      if (q > 16384) q = 16384;
      return (c < 0) ? 16'(-q) : 16'(q);
   endfunction

   function automatic norm_result_type normalize(logic [63:0] word);
      norm_result_type   r;
      logic signed [15:0] c[4];
      longint unsigned   s;
      longint unsigned   m;
      s = 0;
      for (int i = 0; i < 4; i++) begin
         c[i] = word[16*i +: 16];
         s    = s + longint'(int'(c[i]) * int'(c[i]));
      end
      r = '0;
      if (s == 0) begin
         r.zero = 1'b1;
         return r;
      end
      m = int_sqrt(s);
      if (s - m * m > m) m = m + 1;   // round to nearest
      r.len = (m > 65535) ? 16'hFFFF : 16'(m);
      r.uw  = unit_part(c[0], m);
      r.ux  = unit_part(c[1], m);
      r.uy  = unit_part(c[2], m);
      r.uz  = unit_part(c[3], m);
      return r;
   endfunction

   // Receiver: stalls follow a mode switched by the test tasks.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ((cycle_count % 7) < 4);
         endcase
      end
   end

   // Result checker
   always @(posedge clock) begin
      norm_result_type got;
      norm_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32],
                rsp_tdata[63:48], rsp_tdata[79:64], rsp_tuser[0]};
         if (expected_norms.size() == 0) begin
            $display("%t unexpected word: actual %h", $time, got);
            fail_count++;
         end else begin
            want = expected_norms.pop_front();
            if (got.len !== want.len) begin
               $display("%t length: expected %h actual %h", $time, want.len, got.len);
               fail_count++;
            end
            if (got.uw !== want.uw) begin
               $display("%t unit_w: expected %h actual %h", $time, want.uw, got.uw);
               fail_count++;
            end
            if (got.ux !== want.ux) begin
               $display("%t unit_x: expected %h actual %h", $time, want.ux, got.ux);
               fail_count++;
            end
            if (got.uy !== want.uy) begin
               $display("%t unit_y: expected %h actual %h", $time, want.uy, got.uy);
               fail_count++;
            end
            if (got.uz !== want.uz) begin
               $display("%t unit_z: expected %h actual %h", $time, want.uz, got.uz);
               fail_count++;
            end
            if (got.zero !== want.zero) begin
               $display("%t zero_length: expected %b actual %b", $time, want.zero, got.zero);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** quaternion_normalize_top: FAILED **");
         $finish;
      end
   end

   // Present one word; hold it until accepted. valid stays high between
   // back-to-back words, so it is never dropped and raised in one step.
   task automatic send_quat(logic [63:0] word);
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_norms.push_back(normalize(word));
      @(negedge clock);
   endtask

   task automatic idle_gap(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(int'($urandom_range(0, 8)) - 4);        // near zero
         3: return 16'(int'($urandom_range(0, 32768)) - 16384); // |c| <= 1.0
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      stall_mode = 0;
      send_quat(64'h0);                                  // zero magnitude
      send_quat({16'h0, 16'h0, 16'h0, 16'h4000});        // unit w
      send_quat({16'h0, 16'h0, 16'hC000, 16'h0});        // -unit x
      send_quat({16'h0, 16'h4000, 16'h0, 16'h0});
      send_quat({16'hC000, 16'h0, 16'h0, 16'h0});
      send_quat({4{16'h8000}});                          // magnitude saturates
      send_quat({4{16'h7FFF}});
      send_quat({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
      send_quat({16'h0, 16'h0, 16'h0, 16'h0001});        // smallest nonzero
      send_quat({16'hFFFF, 16'h0, 16'h0, 16'h0});
      send_quat({4{16'h0001}});
      send_quat({4{16'hFFFF}});
      send_quat({4{16'h2000}});                          // already unit
      send_quat({16'h0001, 16'h0001, 16'h0, 16'h0});     // length rounds down to 1
      send_quat({16'h0, 16'h0, 16'h0001, 16'h0002});
      send_quat({16'h8000, 16'h0, 16'h0, 16'h0});
      send_quat({16'h0, 16'h8000, 16'h0, 16'h7FFF});
      send_quat({16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0});
      idle_gap(1);
   endtask

   task automatic test_random(int count, int mode);
      int sent;
      int burst;
      stall_mode = mode;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_quat({rand_comp(), rand_comp(), rand_comp(), rand_comp()});
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
      end
      idle_gap(1);
   endtask

   task automatic drain();
      while (expected_norms.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   initial begin
      fail_count  = 0;
      cycle_count = 0;
      stall_mode  = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(400, 0);   // full rate out
      test_random(400, 1);   // light back-pressure
      test_random(350, 2);   // heavy back-pressure
      test_random(300, 3);   // periodic stalls
      stall_mode = 0;
      drain();

      if (fail_count == 0) begin
         $display("** quaternion_normalize_top: PASSED **");
      end else begin
         $display("** quaternion_normalize_top: FAILED **");
      end
      $finish;
   end

endmodule
